[design/abrp_pkg.sv]
package abrp_pkg;

  typedef enum logic [2:0] {
    CMD_MULTI      = 3'd0,
    CMD_SINGLE     = 3'd1,
    CMD_RECOVER    = 3'd2,
    CMD_RECOV_WAIT = 3'd3,
    CMD_DONE_OK    = 3'd4,
    CMD_DONE_ERR   = 3'd5
  } cmd_kind_t;

  localparam logic [1:0] REG_MAX_BURST   = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] REG_STREAK_GOAL = 2'd2;

  localparam logic [3:0] RETRY_LIMIT_RST = 4'd5;
  localparam logic [7:0] STREAK_GOAL_RST = 8'd32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic       en;
    logic [1:0] idx;
    logic [7:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0] max_burst;
    logic [3:0] retry_limit;
    logic [7:0] streak_goal;
  } cfg_regs_t;

  typedef struct packed {
    logic        two_res;
    cmd_kind_t   kind0;
    cmd_kind_t   kind1;
    logic [30:0] sector;
    logic [7:0]  length;
  } plan_t;

endpackage

[design/abrp_if.sv]
interface abrp_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [30:0] start_sector;
  logic [31:0] sector_count;
  logic        outcome_ok;

  modport source(output valid, req_type, start_sector, sector_count, outcome_ok,
                 input ready);
  modport sink(input valid, req_type, start_sector, sector_count, outcome_ok,
               output ready);
endinterface

interface abrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd_kind;
  logic [30:0] cmd_sector;
  logic [7:0]  cmd_length;
  logic        last_of_run;

  modport source(output valid, cmd_kind, cmd_sector, cmd_length, last_of_run,
                 input ready);
  modport sink(input valid, cmd_kind, cmd_sector, cmd_length, last_of_run,
               output ready);
endinterface

[design/abrp_front.sv]
module abrp_front #(
  parameter int MAX_BURST_SECTORS = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  abrp_in_if.sink            in_ch,
  input  abrp_pkg::cfg_wr_t  cfg_wr,
  output abrp_pkg::cfg_regs_t cfg_regs,
  input  logic               q_full,
  output logic               q_push,
  output abrp_pkg::plan_t    q_data
);

  localparam logic [7:0] MAX_B = 8'(MAX_BURST_SECTORS);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MULTI  = 2'd1,
    PH_SINGLE = 2'd2
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  burst_r, burst_nxt;
  logic [7:0]  streak_r, streak_nxt;
  logic [30:0] sector_r, sector_nxt;
  logic [31:0] left_r, left_nxt;
  logic [7:0]  issued_r, issued_nxt;
  logic [3:0]  attempt_r, attempt_nxt;
  logic [7:0]  max_burst_r;
  logic [3:0]  retry_limit_r;
  logic [7:0]  streak_goal_r;

  logic        accept;
  logic        do_good, do_adv, do_issue;
  logic [7:0]  streak_inc;
  logic [8:0]  burst_dbl;
  logic [7:0]  chunk;
  logic [3:0]  attempt_inc;
  logic [7:0]  max_wr;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  assign cfg_regs.max_burst   = max_burst_r;
  assign cfg_regs.retry_limit = retry_limit_r;
  assign cfg_regs.streak_goal = streak_goal_r;

  always_comb begin
    if (cfg_wr.data == 8'd0) begin
      max_wr = 8'd1;
    end else if (cfg_wr.data > MAX_B) begin
      max_wr = MAX_B;
    end else begin
      max_wr = cfg_wr.data;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    burst_nxt      = burst_r;
    streak_nxt     = streak_r;
    sector_nxt     = sector_r;
    left_nxt       = left_r;
    issued_nxt     = issued_r;
    attempt_nxt    = attempt_r;
    q_push         = 1'b0;
    q_data.two_res = 1'b0;
    q_data.kind0   = abrp_pkg::CMD_RECOVER;
    q_data.kind1   = abrp_pkg::CMD_DONE_OK;
    q_data.sector  = '0;
    q_data.length  = '0;
    do_good        = 1'b0;
    do_adv         = 1'b0;
    do_issue       = 1'b0;
    streak_inc     = streak_r + 8'd1;
    burst_dbl      = '0;
    chunk          = '0;
    attempt_inc    = attempt_r + 4'd1;

    if (accept) begin
      if (!in_ch.req_type) begin
        sector_nxt = in_ch.start_sector;
        left_nxt   = in_ch.sector_count;
        do_issue   = 1'b1;
      end else begin
        case (phase_r)
          PH_MULTI, PH_SINGLE: begin
            if (in_ch.outcome_ok) begin
              do_good  = 1'b1;
              do_adv   = 1'b1;
              do_issue = 1'b1;
            end else begin
              q_push         = 1'b1;
              q_data.two_res = 1'b1;
              burst_nxt      = 8'd1;
              streak_nxt     = 8'd0;
              if (phase_r == PH_MULTI) begin
                q_data.kind0  = abrp_pkg::CMD_RECOVER;
                q_data.kind1  = abrp_pkg::CMD_SINGLE;
                q_data.sector = sector_r;
                q_data.length = 8'd1;
                phase_nxt     = PH_SINGLE;
                issued_nxt    = 8'd1;
                attempt_nxt   = 4'd0;
              end else begin
                q_data.kind0 = abrp_pkg::CMD_RECOV_WAIT;
                attempt_nxt  = attempt_inc;
                if (attempt_inc < retry_limit_r) begin
                  q_data.kind1  = abrp_pkg::CMD_SINGLE;
                  q_data.sector = sector_r;
                  q_data.length = 8'd1;
                  issued_nxt    = 8'd1;
                end else begin
                  q_data.kind1 = abrp_pkg::CMD_DONE_ERR;
                  phase_nxt    = PH_IDLE;
                  issued_nxt   = 8'd0;
                  attempt_nxt  = 4'd0;
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
    end

    if (do_good) begin
      if (burst_r == max_burst_r) begin
        streak_nxt = 8'd0;
      end else if (streak_inc >= streak_goal_r) begin
        streak_nxt = 8'd0;
        burst_dbl  = {burst_r, 1'b0};
        burst_nxt  = (burst_dbl > {1'b0, max_burst_r}) ? max_burst_r : burst_dbl[7:0];
      end else begin
        streak_nxt = streak_inc;
      end
    end

    if (do_adv) begin
      sector_nxt = sector_r + {23'd0, issued_r};
      left_nxt   = left_r - {24'd0, issued_r};
    end

    if (do_issue) begin
      q_push = 1'b1;
      if (left_nxt == 32'd0) begin
        phase_nxt    = PH_IDLE;
        issued_nxt   = 8'd0;
        q_data.kind1 = abrp_pkg::CMD_DONE_OK;
      end else begin
        chunk       = ({24'd0, burst_nxt} < left_nxt) ? burst_nxt : left_nxt[7:0];
        attempt_nxt = 4'd0;
        issued_nxt  = chunk;
        q_data.sector = sector_nxt;
        if (chunk > 8'd1) begin
          phase_nxt     = PH_MULTI;
          q_data.kind1  = abrp_pkg::CMD_MULTI;
          q_data.length = chunk;
        end else begin
          phase_nxt     = PH_SINGLE;
          q_data.kind1  = abrp_pkg::CMD_SINGLE;
          q_data.length = 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      burst_r       <= MAX_B;
      streak_r      <= '0;
      sector_r      <= '0;
      left_r        <= '0;
      issued_r      <= '0;
      attempt_r     <= '0;
      max_burst_r   <= MAX_B;
      retry_limit_r <= abrp_pkg::RETRY_LIMIT_RST;
      streak_goal_r <= abrp_pkg::STREAK_GOAL_RST;
    end else if (cfg_wr.en) begin
      case (cfg_wr.idx)
        abrp_pkg::REG_MAX_BURST: begin
          max_burst_r <= max_wr;
          if (burst_r > max_wr) begin
            burst_r <= max_wr;
          end
        end
        abrp_pkg::REG_RETRY_LIMIT: retry_limit_r <= cfg_wr.data[3:0];
        abrp_pkg::REG_STREAK_GOAL: streak_goal_r <= cfg_wr.data;
        default: begin
        end
      endcase
    end else begin
      phase_r   <= phase_nxt;
      burst_r   <= burst_nxt;
      streak_r  <= streak_nxt;
      sector_r  <= sector_nxt;
      left_r    <= left_nxt;
      issued_r  <= issued_nxt;
      attempt_r <= attempt_nxt;
    end
  end

endmodule

[design/abrp_queue.sv]
module abrp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  abrp_pkg::plan_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output abrp_pkg::plan_t head
);

  localparam int CNT_W = $clog2(abrp_pkg::QUEUE_DEPTH + 1);

  abrp_pkg::plan_t                  slot_r [abrp_pkg::QUEUE_DEPTH];
  logic [abrp_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]                 count_r, count_nxt;

  assign full      = (count_r == CNT_W'(abrp_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + abrp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + abrp_pkg::QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

[design/abrp_back.sv]
module abrp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  abrp_pkg::plan_t q_head,
  output logic            q_pop,
  abrp_out_if.source      out_ch
);

  logic                valid_r;
  abrp_pkg::cmd_kind_t kind_r;
  logic [30:0]         sector_r;
  logic [7:0]          length_r;
  logic                last_r;
  logic                pend_r;
  abrp_pkg::cmd_kind_t pend_kind_r;
  logic [30:0]         pend_sector_r;
  logic [7:0]          pend_length_r;
  logic                load;

  assign load  = !valid_r || out_ch.ready;
  assign q_pop = load && !pend_r && q_valid;

  assign out_ch.valid       = valid_r;
  assign out_ch.cmd_kind    = kind_r;
  assign out_ch.cmd_sector  = sector_r;
  assign out_ch.cmd_length  = length_r;
  assign out_ch.last_of_run = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else if (load) begin
      if (pend_r) begin
        valid_r  <= 1'b1;
        pend_r   <= 1'b0;
        kind_r   <= pend_kind_r;
        sector_r <= pend_sector_r;
        length_r <= pend_length_r;
        last_r   <= 1'b1;
      end else if (q_valid) begin
        valid_r <= 1'b1;
        if (q_head.two_res) begin
          pend_r        <= 1'b1;
          pend_kind_r   <= q_head.kind1;
          pend_sector_r <= q_head.sector;
          pend_length_r <= q_head.length;
          kind_r        <= q_head.kind0;
          sector_r      <= '0;
          length_r      <= '0;
          last_r        <= 1'b0;
        end else begin
          kind_r   <= q_head.kind1;
          sector_r <= q_head.sector;
          length_r <= q_head.length;
          last_r   <= 1'b1;
        end
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

endmodule

[design/adaptive_burst_read_planner.sv]
// Adaptive burst read planner. Start requests and read outcomes arrive as
// transactions on in_ch; the read, recover and completion commands leave as
// transactions on out_ch, one command per transaction, with last_of_run set
// on the final command caused by an input transaction.
// The front end accepts an input transaction, updates the planning state and
// writes a plan entry into a four-entry queue; the back end turns each entry
// into one or two output transactions through an output register.
// An input that yields a command passes through a queue slot and the output
// register on its way to out_ch. One input is taken every cycle while the
// queue has room; an entry with two commands holds the output register for
// both in turn; out_ch gives one transaction per cycle while ready is high.
// When the receiver stalls, the output register holds its transaction, the
// queue fills and in_ch.ready falls once all four entries are occupied.
// The user must write registers through the APB port only while idle; the
// block does not check this. Reset clears the queue, the output register and
// the planning state, and returns the registers to their reset values.
module adaptive_burst_read_planner #(
  parameter int MAX_BURST_SECTORS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  abrp_in_if.sink     in_ch,
  abrp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  abrp_pkg::cfg_wr_t   cfg_wr;
  abrp_pkg::cfg_regs_t cfg_regs;
  abrp_pkg::plan_t     push_data;
  abrp_pkg::plan_t     head;
  logic                q_full, q_push, q_pop, q_valid;

  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite;
  assign cfg_wr.idx  = paddr[3:2];
  assign cfg_wr.data = pwdata[7:0];

  always_comb begin
    case (paddr[3:2])
      abrp_pkg::REG_MAX_BURST:   prdata = {24'd0, cfg_regs.max_burst};
      abrp_pkg::REG_RETRY_LIMIT: prdata = {28'd0, cfg_regs.retry_limit};
      abrp_pkg::REG_STREAK_GOAL: prdata = {24'd0, cfg_regs.streak_goal};
      default:                   prdata = '0;
    endcase
  end

  abrp_front #(
    .MAX_BURST_SECTORS(MAX_BURST_SECTORS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg_wr   (cfg_wr),
    .cfg_regs (cfg_regs),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  abrp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  abrp_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int MAX_BURST = 128;
  localparam int DIR_N = 20;
  localparam int PHASE_ITEMS = 75;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MULTI,
    PH_SINGLE
  } plan_phase_t;

  typedef struct packed {
    logic        req_type;
    logic [30:0] start_sector;
    logic [31:0] sector_count;
    logic        outcome_ok;
  } read_req_t;

  typedef struct packed {
    abrp_pkg::cmd_kind_t kind;
    logic [30:0]         sector;
    logic [7:0]          length;
    logic                last;
  } card_cmd_t;

  typedef struct packed {
    read_req_t  req;
    logic       fixed;
    logic [1:0] n_cmds;
    card_cmd_t  c0;
    card_cmd_t  c1;
  } dir_row_t;

  localparam card_cmd_t NONE = '{abrp_pkg::CMD_DONE_OK, 31'd0, 8'd0, 1'b0};

  // Rows with fixed set carry their commands typed in; the rest go through the planner copy.
  dir_row_t dir_rows [DIR_N] = '{
    '{'{1'b0, 31'd0, 32'd0, 1'b0}, 1'b1, 2'd1,
      '{abrp_pkg::CMD_DONE_OK, 31'd0, 8'd0, 1'b1}, NONE},
    '{'{1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 1'b1, 2'd0, NONE, NONE},
    '{'{1'b0, 31'h7FFF_FFFF, 32'd1, 1'b1}, 1'b1, 2'd1,
      '{abrp_pkg::CMD_SINGLE, 31'h7FFF_FFFF, 8'd1, 1'b1}, NONE},
    '{'{1'b1, 31'd0, 32'd0, 1'b1}, 1'b1, 2'd1,
      '{abrp_pkg::CMD_DONE_OK, 31'd0, 8'd0, 1'b1}, NONE},
    '{'{1'b0, 31'h7FFF_FF00, 32'hFFFF_FFFF, 1'b0}, 1'b1, 2'd1,
      '{abrp_pkg::CMD_MULTI, 31'h7FFF_FF00, 8'd128, 1'b1}, NONE},
    '{'{1'b1, 31'h5555_5555, 32'hAAAA_AAAA, 1'b1}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'h2AAA_AAAA, 32'h5555_5555, 1'b1}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'd0, 32'd0, 1'b0}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'd0, 32'd0, 1'b0}, 1'b1, 2'd2,
      '{abrp_pkg::CMD_RECOV_WAIT, 31'd0, 8'd0, 1'b0},
      '{abrp_pkg::CMD_DONE_ERR, 31'd0, 8'd0, 1'b1}},
    '{'{1'b1, 31'd0, 32'd0, 1'b0}, 1'b1, 2'd0, NONE, NONE},
    '{'{1'b0, 31'd100, 32'd5, 1'b0}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'd7, 32'd9, 1'b1}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b0, 31'h5555_5555, 32'd3, 1'b1}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'd0, 32'd0, 1'b0}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b1, 31'd0, 32'd0, 1'b1}, 1'b0, 2'd0, NONE, NONE},
    '{'{1'b0, 31'h2AAA_AAAA, 32'h8000_0000, 1'b0}, 1'b0, 2'd0, NONE, NONE}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        sink_ready = 1'b0;
  bit          no_idle = 1'b0;

  abrp_in_if  in_ch();
  abrp_out_if out_ch();

  assign out_ch.ready = sink_ready;

  adaptive_burst_read_planner #(.MAX_BURST_SECTORS(MAX_BURST)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Planner copy: configuration and planning state.
  logic [7:0]  cfg_max;
  logic [3:0]  cfg_retry;
  logic [7:0]  cfg_goal;
  logic [7:0]  pb_burst;
  logic [7:0]  pb_streak;
  logic [30:0] pb_next;
  logic [31:0] pb_left;
  logic [7:0]  pb_issued;
  logic [3:0]  pb_attempts;
  plan_phase_t pb_phase;

  card_cmd_t cmds_due[$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        cmds_seen = 0;
  int        settings_run = 1;

  function automatic void init_plan();
    cfg_max     = 8'(MAX_BURST);
    cfg_retry   = abrp_pkg::RETRY_LIMIT_RST;
    cfg_goal    = abrp_pkg::STREAK_GOAL_RST;
    pb_burst    = 8'(MAX_BURST);
    pb_streak   = 8'd0;
    pb_next     = 31'd0;
    pb_left     = 32'd0;
    pb_issued   = 8'd0;
    pb_attempts = 4'd0;
    pb_phase    = PH_IDLE;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [31:0] val);
    logic [7:0] m;
    case (idx)
      abrp_pkg::REG_MAX_BURST: begin
        m = val[7:0];
        if (m == 8'd0) m = 8'd1;
        if (m > 8'(MAX_BURST)) m = 8'(MAX_BURST);
        cfg_max = m;
        if (pb_burst > cfg_max) pb_burst = cfg_max;
      end
      abrp_pkg::REG_RETRY_LIMIT: cfg_retry = val[3:0];
      abrp_pkg::REG_STREAK_GOAL: cfg_goal = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic void emit(abrp_pkg::cmd_kind_t k, logic [30:0] s, logic [7:0] l,
                               logic last, bit keep);
    if (keep) cmds_due.push_back('{k, s, l, last});
  endfunction

  function automatic void credit_success();
    logic [8:0] wide;
    if (pb_burst == cfg_max) begin
      pb_streak = 8'd0;
    end else begin
      pb_streak = pb_streak + 8'd1;
      if (pb_streak >= cfg_goal) begin
        wide = {pb_burst, 1'b0};
        pb_streak = 8'd0;
        if (wide > {1'b0, cfg_max}) wide = {1'b0, cfg_max};
        pb_burst = wide[7:0];
      end
    end
  endfunction

  function automatic void collapse_burst();
    pb_streak = 8'd0;
    pb_burst  = 8'd1;
  endfunction

  function automatic void move_window(logic [7:0] n);
    pb_next = pb_next + 31'(n);
    pb_left = pb_left - 32'(n);
  endfunction

  function automatic void issue_read(bit keep);
    logic [31:0] chunk;
    if (pb_left == 32'd0) begin
      pb_phase  = PH_IDLE;
      pb_issued = 8'd0;
      emit(abrp_pkg::CMD_DONE_OK, 31'd0, 8'd0, 1'b1, keep);
    end else begin
      chunk = ({24'd0, pb_burst} < pb_left) ? {24'd0, pb_burst} : pb_left;
      pb_attempts = 4'd0;
      pb_issued = chunk[7:0];
      if (chunk > 32'd1) begin
        pb_phase = PH_MULTI;
        emit(abrp_pkg::CMD_MULTI, pb_next, chunk[7:0], 1'b1, keep);
      end else begin
        pb_phase = PH_SINGLE;
        emit(abrp_pkg::CMD_SINGLE, pb_next, 8'd1, 1'b1, keep);
      end
    end
  endfunction

  function automatic void plan_step(read_req_t r, bit keep);
    if (!r.req_type) begin
      pb_next = r.start_sector;
      pb_left = r.sector_count;
      issue_read(keep);
    end else if (pb_phase == PH_MULTI) begin
      if (r.outcome_ok) begin
        credit_success();
        move_window(pb_issued);
        issue_read(keep);
      end else begin
        collapse_burst();
        emit(abrp_pkg::CMD_RECOVER, 31'd0, 8'd0, 1'b0, keep);
        pb_phase    = PH_SINGLE;
        pb_issued   = 8'd1;
        pb_attempts = 4'd0;
        emit(abrp_pkg::CMD_SINGLE, pb_next, 8'd1, 1'b1, keep);
      end
    end else if (pb_phase == PH_SINGLE) begin
      if (r.outcome_ok) begin
        credit_success();
        move_window(8'd1);
        issue_read(keep);
      end else begin
        collapse_burst();
        pb_attempts = pb_attempts + 4'd1;
        emit(abrp_pkg::CMD_RECOV_WAIT, 31'd0, 8'd0, 1'b0, keep);
        if (pb_attempts < cfg_retry) begin
          pb_issued = 8'd1;
          emit(abrp_pkg::CMD_SINGLE, pb_next, 8'd1, 1'b1, keep);
        end else begin
          pb_phase    = PH_IDLE;
          pb_issued   = 8'd0;
          pb_attempts = 4'd0;
          emit(abrp_pkg::CMD_DONE_ERR, 31'd0, 8'd0, 1'b1, keep);
        end
      end
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    card_cmd_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && sink_ready) begin
      cmds_seen++;
      if (cmds_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: unexpected command, expected none, got kind %0d sector %0h length %0d",
                   $time, out_ch.cmd_kind, out_ch.cmd_sector, out_ch.cmd_length);
      end else begin
        want = cmds_due.pop_front();
        check_field("cmd_kind", 32'(want.kind), 32'(out_ch.cmd_kind));
        check_field("cmd_sector", 32'(want.sector), 32'(out_ch.cmd_sector));
        check_field("cmd_length", 32'(want.length), 32'(out_ch.cmd_length));
        check_field("last_of_run", 32'(want.last), 32'(out_ch.last_of_run));
      end
    end
    sink_ready <= no_idle || ($urandom_range(99) >= 9);
  end

  task automatic send_req(read_req_t r, bit keep);
    if (!no_idle && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= r.req_type;
    in_ch.start_sector <= r.start_sector;
    in_ch.sector_count <= r.sector_count;
    in_ch.outcome_ok   <= r.outcome_ok;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    plan_step(r, keep);
    items_sent++;
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    logic [31:0] word;
    word = {24'($urandom), val};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    apply_reg(idx, word);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    for (int i = 0; i < 2000 && cmds_due.size() != 0; i++) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_traffic(int n);
    read_req_t r;
    int        counted;
    int        fail_pct;
    counted  = 0;
    fail_pct = 0;
    while (counted < n) begin
      r.start_sector = 31'($urandom);
      r.sector_count = $urandom;
      r.outcome_ok   = 1'($urandom);
      if (pb_phase == PH_IDLE && $urandom_range(99) < 8) begin
        r.req_type = 1'b1;
        send_req(r, 1'b1);
      end else begin
        if (pb_phase == PH_IDLE || $urandom_range(99) < 4) begin
          r.req_type = 1'b0;
          case ($urandom_range(9))
            0:       r.start_sector = 31'd0;
            1, 2:    r.start_sector = 31'h7FFF_FFFF - 31'($urandom_range(300));
            default: ;
          endcase
          case ($urandom_range(19))
            0:       r.sector_count = 32'd0;
            1:       r.sector_count = 32'hFFFF_FFFF;
            2:       ;
            3, 4, 5, 6, 7, 8: r.sector_count = $urandom_range(400, 1);
            default: r.sector_count = $urandom_range(40, 1);
          endcase
          case ($urandom_range(3))
            0:       fail_pct = 0;
            1:       fail_pct = 5;
            2:       fail_pct = 20;
            default: fail_pct = 60;
          endcase
        end else begin
          r.req_type   = 1'b1;
          r.outcome_ok = ($urandom_range(99) >= fail_pct);
        end
        send_req(r, 1'b1);
        counted++;
      end
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.req_type     <= 1'b0;
    in_ch.start_sector <= 31'd0;
    in_ch.sector_count <= 32'd0;
    in_ch.outcome_ok   <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= 4'd0;
    pwdata             <= 32'd0;
    init_plan();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      send_req(dir_rows[i].req, !dir_rows[i].fixed);
      if (dir_rows[i].fixed && dir_rows[i].n_cmds >= 2'd1) cmds_due.push_back(dir_rows[i].c0);
      if (dir_rows[i].fixed && dir_rows[i].n_cmds == 2'd2) cmds_due.push_back(dir_rows[i].c1);
    end
    run_traffic(PHASE_ITEMS);
    settle();

    for (int ph = 1; ph <= 5; ph++) begin
      no_idle = (ph == 2);
      case (ph)
        1: begin
          cfg_write(abrp_pkg::REG_MAX_BURST, 8'd0);
          cfg_write(abrp_pkg::REG_RETRY_LIMIT, 8'd0);
          cfg_write(abrp_pkg::REG_STREAK_GOAL, 8'd0);
        end
        2: begin
          cfg_write(abrp_pkg::REG_MAX_BURST, 8'd255);
          cfg_write(abrp_pkg::REG_RETRY_LIMIT, 8'd15);
          cfg_write(abrp_pkg::REG_STREAK_GOAL, 8'd255);
        end
        3: begin
          cfg_write(abrp_pkg::REG_MAX_BURST, 8'd6);
          cfg_write(abrp_pkg::REG_RETRY_LIMIT, 8'd1);
          cfg_write(abrp_pkg::REG_STREAK_GOAL, 8'd1);
        end
        4: begin
          cfg_write(abrp_pkg::REG_MAX_BURST, 8'd2);
          cfg_write(abrp_pkg::REG_RETRY_LIMIT, 8'd3);
          cfg_write(abrp_pkg::REG_STREAK_GOAL, 8'd2);
        end
        default: begin
          cfg_write(abrp_pkg::REG_MAX_BURST, 8'd128);
          cfg_write(abrp_pkg::REG_RETRY_LIMIT, 8'($urandom_range(15, 1)));
          cfg_write(abrp_pkg::REG_STREAK_GOAL, 8'($urandom_range(8, 1)));
        end
      endcase
      settings_run++;
      run_traffic(PHASE_ITEMS);
      settle();
    end

    if (cmds_due.size() != 0) begin
      mismatches += cmds_due.size();
      $display("%0t: %0d expected commands never arrived, expected kind %0d, got none",
               $time, cmds_due.size(), cmds_due[0].kind);
    end
    $display("Sent %0d input transactions and checked %0d command transactions",
             items_sent, cmds_seen);
    $display("across %0d register settings, including the clamped and zero extremes.",
             settings_run);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Run timed out with %0d commands outstanding.", cmds_due.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
design/abrp_pkg.sv
design/abrp_if.sv
design/abrp_front.sv
design/abrp_queue.sv
design/abrp_back.sv
design/adaptive_burst_read_planner.sv
tb/sv/tb.sv
